// File: rtl/core/ybr_pkg.sv
// Shared constants and types for the Y/Cb/Cr byte to RGB converter.
package ybr_pkg;

   localparam int SAMPLE_W         = 8;
   localparam int LUMA_MIN         = 16;
   localparam int LUMA_MAX         = 235;
   localparam int CHROMA_MIN       = 16;
   localparam int CHROMA_MAX       = 240;
   localparam int CHROMA_MID       = 128;
   localparam int FULL_SCALE       = 255;
   localparam int LUMA_SPAN        = 219;
   localparam int CHROMA_HALF_SPAN = 112;
   localparam int CHROMA_GAIN      = 2;
   localparam int LIMITED_DEN      = LUMA_SPAN * CHROMA_HALF_SPAN;

   localparam int WEIGHT_W  = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RESET  = 16'd13933;
   localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RESET = 16'd4732;

   localparam int QUOT_W = 8;
   localparam int LANES  = 3;

   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMITED_RANGE = 2'd0,
      CSR_RED_WEIGHT    = 2'd1,
      CSR_BLUE_WEIGHT   = 2'd2
   } csr_index_type;

endpackage

// File: rtl/core/ycbcr_byte_to_rgb.sv
// Pipelined Y/Cb/Cr byte to RGB converter with configurable luma weights.
// The pipeline has 14 register stages.
// Throughput: one transaction per cycle; req_ready falls only when a stall backs up
// through every stage, and the depth is set by the eight step restoring divider.
// Reset clears all stage valid bits, loads the register reset values and holds
// req_ready low.
module ycbcr_byte_to_rgb #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ybr_pkg::SAMPLE_W-1:0]      req_luma,
   input  logic [ybr_pkg::SAMPLE_W-1:0]      req_chroma_blue,
   input  logic [ybr_pkg::SAMPLE_W-1:0]      req_chroma_red,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ybr_pkg::SAMPLE_W-1:0]      rsp_red,
   output logic [ybr_pkg::SAMPLE_W-1:0]      rsp_green,
   output logic [ybr_pkg::SAMPLE_W-1:0]      rsp_blue,
   output logic                              rsp_clipped,
   input  logic                              csr_write_enable,
   input  logic [ybr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ybr_pkg::CSR_W-1:0]         csr_data
);

   localparam int F  = WEIGHT_FRAC_BITS;
   localparam int SW = ybr_pkg::SAMPLE_W;
   localparam int WW = ybr_pkg::WEIGHT_W;
   localparam int UW = (F + 1 > WW) ? F + 1 : WW;
   localparam int AW = UW + 1;
   localparam int GW = UW + 2;
   localparam int PW = AW + WW + 1;
   localparam int KW = F + 1;
   localparam int DW = 2 * F + 16;
   localparam int RW = AW + SW;
   localparam int TW = PW + SW;
   localparam int XW = KW + SW;
   localparam int MW = ((2 * F + 15 > UW + 32) ? 2 * F + 15 : UW + 32) + 2;
   localparam int NW = MW + 7;
   localparam int CW = (NW > DW + 8) ? NW : DW + 8;
   localparam int QW = ybr_pkg::QUOT_W;
   localparam int LN = ybr_pkg::LANES;
   localparam int DIV_STEPS = QW;
   localparam int DIV_FIRST = 4;
   localparam int NS = DIV_FIRST + DIV_STEPS + 2;

   localparam logic signed [GW-1:0] ONE_G = GW'(64'sd1 <<< F);

   function automatic logic [SW-1:0] clamp_byte(input logic [SW-1:0] v,
                                                input logic [SW-1:0] lo,
                                                input logic [SW-1:0] hi);
      logic [SW-1:0] r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

   // Configuration registers.
   logic          lim_ff, lim_in;
   logic [WW-1:0] kr_ff, kr_in;
   logic [WW-1:0] kb_ff, kb_in;

   always_comb begin
      lim_in = lim_ff;
      kr_in  = kr_ff;
      kb_in  = kb_ff;
      if (csr_write_enable) begin
         case (ybr_pkg::csr_index_type'(csr_index))
            ybr_pkg::CSR_LIMITED_RANGE: begin
               lim_in = csr_data[0];
            end
            ybr_pkg::CSR_RED_WEIGHT: begin
               kr_in = csr_data[WW-1:0];
            end
            ybr_pkg::CSR_BLUE_WEIGHT: begin
               kb_in = csr_data[WW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= 1'b0;
         kr_ff  <= ybr_pkg::RED_WEIGHT_RESET;
         kb_ff  <= ybr_pkg::BLUE_WEIGHT_RESET;
      end else begin
         lim_ff <= lim_in;
         kr_ff  <= kr_in;
         kb_ff  <= kb_in;
      end
   end

   // Weight-derived terms, refreshed every cycle from the configuration registers.
   logic signed [AW-1:0] a_r_ff, a_r_in, a_b_ff, a_b_in;
   logic signed [PW-1:0] pr_ff, pr_in, pb_ff, pb_in;
   logic signed [GW-1:0] kg_full;
   logic [KW-1:0]        kg_ff, kg_in;
   logic                 green_ok_ff, green_ok_in;
   logic [DW-1:0]        den_rb_ff, den_rb_in, den_g_ff, den_g_in;

   always_comb begin
      a_r_in      = AW'(ONE_G) - signed'(AW'(kr_ff));
      a_b_in      = AW'(ONE_G) - signed'(AW'(kb_ff));
      pr_in       = PW'(a_r_in) * PW'(signed'({1'b0, kr_ff}));
      pb_in       = PW'(a_b_in) * PW'(signed'({1'b0, kb_ff}));
      kg_full     = ONE_G - signed'(GW'(kr_ff)) - signed'(GW'(kb_ff));
      green_ok_in = kg_full > 0;
      kg_in       = kg_full[KW-1:0];
      if (lim_ff) begin
         den_rb_in = DW'(ybr_pkg::LIMITED_DEN) << F;
         den_g_in  = (DW'(ybr_pkg::LIMITED_DEN) * DW'(kg_in)) << F;
      end else begin
         den_rb_in = DW'(1) << F;
         den_g_in  = DW'(kg_in) << F;
      end
   end

   always_ff @(posedge clock) begin
      a_r_ff      <= a_r_in;
      a_b_ff      <= a_b_in;
      pr_ff       <= pr_in;
      pb_ff       <= pb_in;
      kg_ff       <= kg_in;
      green_ok_ff <= green_ok_in;
      den_rb_ff   <= den_rb_in;
      den_g_ff    <= den_g_in;
   end

   // Stage valid bits and stall chain.
   logic [NS-1:0] v_ff, v_in;
   logic [NS-1:0] en;

   assign en[NS-1] = !v_ff[NS-1] || rsp_ready;
   for (genvar i = 0; i < NS - 1; i++) begin : g_en
      assign en[i] = !v_ff[i] || en[i+1];
   end

   assign v_in[0] = en[0] ? req_valid : v_ff[0];
   for (genvar i = 1; i < NS; i++) begin : g_vin
      assign v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0] && !reset;

   // Stage 0: clamp the samples, center the chroma and, in limited range, offset the luma.
   logic [SW-1:0]        lc, cb_c, cr_c;
   logic [SW-1:0]        lx_ff, lx_in;
   logic signed [SW-1:0] yc_ff, yc_in, zc_ff, zc_in;

   always_comb begin
      lc    = clamp_byte(req_luma, SW'(ybr_pkg::LUMA_MIN), SW'(ybr_pkg::LUMA_MAX));
      cb_c  = clamp_byte(req_chroma_blue, SW'(ybr_pkg::CHROMA_MIN),
                         SW'(ybr_pkg::CHROMA_MAX));
      cr_c  = clamp_byte(req_chroma_red, SW'(ybr_pkg::CHROMA_MIN),
                         SW'(ybr_pkg::CHROMA_MAX));
      lx_in = lim_ff ? lc - SW'(ybr_pkg::LUMA_MIN) : lc;
      yc_in = signed'(cb_c - SW'(ybr_pkg::CHROMA_MID));
      zc_in = signed'(cr_c - SW'(ybr_pkg::CHROMA_MID));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lx_ff <= lx_in;
         yc_ff <= yc_in;
         zc_ff <= zc_in;
      end
   end

   // Stage 1: chroma and luma products with the weights.
   logic signed [RW-1:0] rz_ff, rz_in, by_ff, by_in;
   logic signed [TW-1:0] gz_ff, gz_in, gy_ff, gy_in;
   logic [XW-1:0]        xk_ff, xk_in;
   logic [SW-1:0]        lx2_ff, lx2_in;

   always_comb begin
      rz_in  = RW'(zc_ff) * RW'(a_r_ff);
      by_in  = RW'(yc_ff) * RW'(a_b_ff);
      gz_in  = TW'(zc_ff) * TW'(pr_ff);
      gy_in  = TW'(yc_ff) * TW'(pb_ff);
      xk_in  = XW'(lx_ff) * XW'(kg_ff);
      lx2_in = lx_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rz_ff  <= rz_in;
         by_ff  <= by_in;
         gz_ff  <= gz_in;
         gy_ff  <= gy_in;
         xk_ff  <= xk_in;
         lx2_ff <= lx2_in;
      end
   end

   // Stage 2: signed numerators of the three channels.
   logic signed [MW-1:0] lrb, lg, t_sum, t_gain, r_gain, b_gain;
   logic signed [MW-1:0] m_ff [LN];
   logic signed [MW-1:0] m_in [LN];

   always_comb begin
      t_sum = MW'(gz_ff) + MW'(gy_ff);
      if (lim_ff) begin
         lrb    = (signed'(MW'(lx2_ff)) * MW'(ybr_pkg::CHROMA_HALF_SPAN)) <<< F;
         lg     = (signed'(MW'(xk_ff)) * MW'(ybr_pkg::CHROMA_HALF_SPAN)) <<< F;
         r_gain = MW'(rz_ff) * MW'(ybr_pkg::LUMA_SPAN);
         b_gain = MW'(by_ff) * MW'(ybr_pkg::LUMA_SPAN);
         t_gain = t_sum * MW'(ybr_pkg::LUMA_SPAN);
      end else begin
         lrb    = signed'(MW'(lx2_ff)) <<< F;
         lg     = signed'(MW'(xk_ff)) <<< F;
         r_gain = MW'(rz_ff) * MW'(ybr_pkg::CHROMA_GAIN);
         b_gain = MW'(by_ff) * MW'(ybr_pkg::CHROMA_GAIN);
         t_gain = t_sum * MW'(ybr_pkg::CHROMA_GAIN);
      end
      m_in[ybr_pkg::LANE_RED]   = lrb + r_gain;
      m_in[ybr_pkg::LANE_BLUE]  = lrb + b_gain;
      m_in[ybr_pkg::LANE_GREEN] = lg - t_gain;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         m_ff <= m_in;
      end
   end

   // Stage 3: magnitude and output scale of each numerator.
   logic [MW-2:0] mag [LN];
   logic [NW-1:0] num_ff [LN];
   logic [NW-1:0] num_in [LN];
   logic          neg_ff [LN];
   logic          neg_in [LN];

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         neg_in[l] = m_ff[l][MW-1];
         mag[l]    = neg_in[l] ? (MW-1)'(-m_ff[l]) : (MW-1)'(m_ff[l]);
         num_in[l] = lim_ff ? NW'(mag[l]) * NW'(ybr_pkg::FULL_SCALE) : NW'(mag[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         num_ff <= num_in;
         neg_ff <= neg_in;
      end
   end

   // Divider: a saturation check, then one quotient bit per stage.
   logic [DW-1:0] den_w [LN];
   logic [CW-1:0] rem_ff  [DIV_STEPS][LN];
   logic [CW-1:0] rem_in  [DIV_STEPS][LN];
   logic [QW-1:0] q_ff    [1:DIV_STEPS][LN];
   logic [QW-1:0] q_in    [1:DIV_STEPS][LN];
   logic          dsat_ff [DIV_STEPS+1][LN];
   logic          dsat_in [DIV_STEPS+1][LN];
   logic          dneg_ff [DIV_STEPS+1][LN];
   logic          dneg_in [DIV_STEPS+1][LN];

   for (genvar l = 0; l < LN; l++) begin : g_div_in
      assign den_w[l]      = (l == ybr_pkg::LANE_GREEN) ? den_g_ff : den_rb_ff;
      assign dsat_in[0][l] = CW'(num_ff[l]) >= (CW'(den_w[l]) << DIV_STEPS);
      assign dneg_in[0][l] = neg_ff[l];
      assign rem_in[0][l]  = CW'(num_ff[l]);
   end

   always_ff @(posedge clock) begin
      if (en[DIV_FIRST]) begin
         dsat_ff[0] <= dsat_in[0];
         dneg_ff[0] <= dneg_in[0];
         rem_ff[0]  <= rem_in[0];
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      for (genvar l = 0; l < LN; l++) begin : g_lane
         logic [CW-1:0] shifted;
         logic          hit;
         logic [QW-1:0] q_prev;

         assign shifted = CW'(den_w[l]) << (DIV_STEPS - j);
         assign hit     = rem_ff[j-1][l] >= shifted;
         if (j == 1) begin : g_q0
            assign q_prev = '0;
         end else begin : g_qn
            assign q_prev = q_ff[j-1][l];
         end
         assign q_in[j][l]    = q_prev | (QW'(hit) << (DIV_STEPS - j));
         assign dsat_in[j][l] = dsat_ff[j-1][l];
         assign dneg_in[j][l] = dneg_ff[j-1][l];
         if (j < DIV_STEPS) begin : g_rem
            assign rem_in[j][l] = hit ? rem_ff[j-1][l] - shifted : rem_ff[j-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (en[DIV_FIRST+j]) begin
            q_ff[j]    <= q_in[j];
            dsat_ff[j] <= dsat_in[j];
            dneg_ff[j] <= dneg_in[j];
         end
      end

      if (j < DIV_STEPS) begin : g_rem_reg
         always_ff @(posedge clock) begin
            if (en[DIV_FIRST+j]) begin
               rem_ff[j] <= rem_in[j];
            end
         end
      end
   end

   // Output stage: saturation and the clipped flag.
   logic [SW-1:0] byte_out [LN];
   logic [LN-1:0] lane_clip;
   logic [SW-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic          clip_ff, clip_in;

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         if (dneg_ff[DIV_STEPS][l]) begin
            byte_out[l]  = '0;
            lane_clip[l] = dsat_ff[DIV_STEPS][l] || (q_ff[DIV_STEPS][l] != '0);
         end else if (dsat_ff[DIV_STEPS][l]) begin
            byte_out[l]  = '1;
            lane_clip[l] = 1'b1;
         end else begin
            byte_out[l]  = SW'(q_ff[DIV_STEPS][l]);
            lane_clip[l] = 1'b0;
         end
      end
      red_in  = byte_out[ybr_pkg::LANE_RED];
      blue_in = byte_out[ybr_pkg::LANE_BLUE];
      if (green_ok_ff) begin
         green_in = byte_out[ybr_pkg::LANE_GREEN];
         clip_in  = |lane_clip;
      end else begin
         green_in = '0;
         clip_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_valid   = v_ff[NS-1];
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_clipped = clip_ff;

   // An accepted transaction always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // Back pressure reaches the input only when the first stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v_ff[0])
      else $error("input stalled with an empty first stage");

   // An empty output register takes the last divider stage on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (!v_ff[NS-1] && v_ff[NS-2]) |=> v_ff[NS-1])
      else $error("output register failed to load");

   // A non-positive green weight always flags the result.
   assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-2] && en[NS-1] && !green_ok_ff) |=> rsp_clipped)
      else $error("green weight fault not flagged");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the Y/Cb/Cr byte to RGB converter.
`timescale 1ns / 100ps

module testbench;

   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int LATENCY_CYCLES   = 14;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_PIXELS     = 78;
   localparam int SW               = ybr_pkg::SAMPLE_W;

   typedef struct {
      logic [SW-1:0] red;
      logic [SW-1:0] green;
      logic [SW-1:0] blue;
      logic          clipped;
   } rgb_pixel_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [SW-1:0]                req_luma = '0;
   logic [SW-1:0]                req_chroma_blue = '0;
   logic [SW-1:0]                req_chroma_red = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [SW-1:0]                rsp_red;
   logic [SW-1:0]                rsp_green;
   logic [SW-1:0]                rsp_blue;
   logic                         rsp_clipped;
   logic                         csr_write_enable = 1'b0;
   ybr_pkg::csr_index_type       csr_index = ybr_pkg::CSR_LIMITED_RANGE;
   logic [ybr_pkg::CSR_W-1:0]    csr_data = '0;

   bit                           cfg_limited = 1'b0;
   logic [ybr_pkg::WEIGHT_W-1:0] cfg_red_weight = ybr_pkg::RED_WEIGHT_RESET;
   logic [ybr_pkg::WEIGHT_W-1:0] cfg_blue_weight = ybr_pkg::BLUE_WEIGHT_RESET;

   rgb_pixel_type                expected_pixels[$];
   int                           failures = 0;
   int                           send_idle_pct = 0;
   int                           rsp_stall_pct = 0;
   int                           quiet_cycles = 0;

   ycbcr_byte_to_rgb #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_luma        (req_luma),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_clipped     (rsp_clipped),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_sample(logic [SW-1:0] s, int lo, int hi);
      if (s < lo) return lo;
      if (s > hi) return hi;
      return s;
   endfunction

   // Truncates scale * num / den toward zero, then saturates to a byte.
   function automatic logic [SW-1:0] saturate_channel(longint num, longint den,
                                                     longint scale, inout bit clip);
      longint mag;
      longint val;
      mag = (num < 0) ? -num : num;
      val = (mag * scale) / den;
      if (num < 0) begin
         if (val != 0) clip = 1'b1;
         return '0;
      end
      if (val > 255) begin
         clip = 1'b1;
         return 8'd255;
      end
      return 8'(val);
   endfunction

   function automatic rgb_pixel_type convert_pixel(logic [SW-1:0] y,
                                                   logic [SW-1:0] cb,
                                                   logic [SW-1:0] cr);
      longint luma_c, cb_c, cr_c, unity, kr, kb, kg, cross_term, luma_term;
      longint den, gain, scale;
      bit clip;
      rgb_pixel_type px;
      luma_c = clamp_sample(y, ybr_pkg::LUMA_MIN, ybr_pkg::LUMA_MAX);
      cb_c   = clamp_sample(cb, ybr_pkg::CHROMA_MIN, ybr_pkg::CHROMA_MAX)
               - ybr_pkg::CHROMA_MID;
      cr_c   = clamp_sample(cr, ybr_pkg::CHROMA_MIN, ybr_pkg::CHROMA_MAX)
               - ybr_pkg::CHROMA_MID;
      unity  = longint'(1) << WEIGHT_FRAC_BITS;
      kr     = cfg_red_weight;
      kb     = cfg_blue_weight;
      kg     = unity - kr - kb;
      clip   = 1'b0;
      if (cfg_limited) begin
         den       = longint'(ybr_pkg::LIMITED_DEN) * unity;
         gain      = ybr_pkg::LUMA_SPAN;
         scale     = ybr_pkg::FULL_SCALE;
         luma_term = longint'(ybr_pkg::CHROMA_HALF_SPAN) * (luma_c - ybr_pkg::LUMA_MIN)
                     * unity;
      end else begin
         den       = unity;
         gain      = ybr_pkg::CHROMA_GAIN;
         scale     = 1;
         luma_term = luma_c * unity;
      end
      px.red  = saturate_channel(luma_term + gain * cr_c * (unity - kr), den, scale, clip);
      px.blue = saturate_channel(luma_term + gain * cb_c * (unity - kb), den, scale, clip);
      if (kg > 0) begin
         cross_term = cb_c * (unity - kb) * kb + cr_c * (unity - kr) * kr;
         px.green   = saturate_channel(luma_term * kg - gain * cross_term, den * kg,
                                       scale, clip);
      end else begin
         px.green = '0;
         clip     = 1'b1;
      end
      px.clipped = clip;
      return px;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected transaction: red %0d green %0d blue %0d clipped %0d",
                   rsp_red, rsp_green, rsp_blue, rsp_clipped);
            failures++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red);
               failures++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green);
               failures++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
               failures++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0d, got %0d", want.clipped, rsp_clipped);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [SW-1:0] y, input logic [SW-1:0] cb,
                             input logic [SW-1:0] cr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_luma        <= y;
      req_chroma_blue <= cb;
      req_chroma_red  <= cr;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(convert_pixel(y, cb, cr));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_weights(input bit limited,
                                input logic [ybr_pkg::WEIGHT_W-1:0] kr,
                                input logic [ybr_pkg::WEIGHT_W-1:0] kb);
      csr_write_enable <= 1'b1;
      csr_index        <= ybr_pkg::CSR_LIMITED_RANGE;
      csr_data         <= {15'($urandom_range(32767)), limited};
      @(posedge clock);
      csr_index        <= ybr_pkg::CSR_RED_WEIGHT;
      csr_data         <= kr;
      @(posedge clock);
      csr_index        <= ybr_pkg::CSR_BLUE_WEIGHT;
      csr_data         <= kb;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_limited     = limited;
      cfg_red_weight  = kr;
      cfg_blue_weight = kb;
   endtask

   function automatic logic [SW-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'(ybr_pkg::LUMA_MIN + $urandom_range(2) - 1);
         3: return 8'(ybr_pkg::LUMA_MAX + $urandom_range(2) - 1);
         4: return 8'(ybr_pkg::CHROMA_MAX + $urandom_range(2) - 1);
         5: return 8'(ybr_pkg::CHROMA_MID);
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_reset_weights();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd16, 8'd128, 8'd128);
      send_pixel(8'd235, 8'd128, 8'd128);
      send_pixel(8'd235, 8'd240, 8'd240);
      send_pixel(8'd16, 8'd16, 8'd16);
      send_pixel(8'd128, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd0, 8'd255);
      drain_pipeline();
   endtask

   task automatic test_limited_range();
      write_weights(1'b1, 16'd13933, 16'd4732);
      send_pixel(8'd16, 8'd128, 8'd128);
      send_pixel(8'd235, 8'd128, 8'd128);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd17, 8'd127, 8'd127);
      send_pixel(8'd81, 8'd90, 8'd240);
      drain_pipeline();
   endtask

   task automatic test_green_weight_edges();
      write_weights(1'b0, 16'd65535, 16'd65535);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd235, 8'd128, 8'd128);
      drain_pipeline();
      write_weights(1'b1, 16'd32768, 16'd32768);
      send_pixel(8'd120, 8'd60, 8'd180);
      drain_pipeline();
      write_weights(1'b1, 16'd0, 16'd0);
      send_pixel(8'd200, 8'd16, 8'd240);
      drain_pipeline();
      write_weights(1'b0, 16'd0, 16'd0);
      send_pixel(8'd60, 8'd240, 8'd16);
      drain_pipeline();
   endtask

   task automatic test_random_phases();
      logic [ybr_pkg::WEIGHT_W-1:0] kr, kb;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(3))
            0: begin
               case ($urandom_range(2))
                  0: begin kr = 16'd19595; kb = 16'd7471; end
                  1: begin kr = 16'd13933; kb = 16'd4732; end
                  default: begin kr = 16'd17224; kb = 16'd3880; end
               endcase
            end
            1: begin
               kr = 16'($urandom_range(65535));
               kb = 16'($urandom_range(65535 - kr));
            end
            2: begin
               kr = 16'($urandom_range(65535));
               kb = 16'($urandom_range(65535));
            end
            default: begin
               kr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               kb = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
         endcase
         write_weights(1'($urandom_range(1)), kr, kb);
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         repeat (PHASE_PIXELS) send_pixel(pick_sample(), pick_sample(), pick_sample());
         drain_pipeline();
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_weights();
      test_limited_range();
      test_green_weight_edges();
      test_random_phases();
      repeat (LATENCY_CYCLES + 6) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d transactions never returned", expected_pixels.size());
         failures++;
      end
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: ycbcr_byte_to_rgb.f
rtl/core/ybr_pkg.sv
rtl/core/ycbcr_byte_to_rgb.sv
sim/testbench.sv
